@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, expr)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ src/h2b_pkg.sv @@
// ----------------------------------------------------------------------------
// h2b_pkg
// Types, codes and lookup functions of the hex text to Base64 encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package h2b_pkg;

   localparam int MaxResults = 5;
   localparam int ResCntW    = $clog2(MaxResults + 1);

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_HEX = 2'd1;
   localparam logic [1:0] STATUS_ODD     = 2'd2;

   localparam logic [7:0] CHAR_PAD     = 8'h3D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef struct packed {
      logic [3:0] pending_nibble;
      logic       nibble_held;
      logic [1:0] byte_count;
      logic       discarding;
   } state_type;

   typedef struct packed {
      logic       en;
      logic       idx;
      logic [7:0] data;
   } hold_wr_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [1:0] status;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [ResCntW-1:0]            cnt;
      item_type [MaxResults-1:0]     items;
   } burst_type;

   // bit 4 set marks a non-hex character
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         v = {1'b0, c[3:0] + 4'd9};
      return v;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26)       c = 8'h41 + {2'b00, v};
      else if (v < 6'd52)  c = 8'h61 + {2'b00, v - 6'd26};
      else if (v < 6'd62)  c = 8'h30 + {2'b00, v - 6'd52};
      else if (v == 6'd62) c = 8'h2B;
      else                 c = 8'h2F;
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/h2b_encode.sv @@
// ----------------------------------------------------------------------------
// h2b_encode
// One-pass step: next state, held byte write and result burst for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2b_encode (
   input  wire h2b_pkg::state_type   state,
   input  wire logic [7:0]           held0,
   input  wire logic [7:0]           held1,
   input  wire logic [7:0]           char_in,
   input  wire logic                 end_mark,
   output h2b_pkg::state_type        state_nx,
   output h2b_pkg::hold_wr_type      hold_wr,
   output h2b_pkg::burst_type        burst
);

   logic [4:0]  hv;
   logic [7:0]  new_byte;
   logic        is_space;
   logic [1:0]  gcnt;
   logic [23:0] word;
   h2b_pkg::item_type [3:0] grp;

   always_comb begin
      hv       = h2b_pkg::hex_value(char_in);
      new_byte = {state.pending_nibble, hv[3:0]};
      is_space = (char_in inside {[8'h09:8'h0D], 8'h20});
   end

   // group of up to three bytes into four characters
   always_comb begin
      if (end_mark) begin
         gcnt = (state.byte_count == 2'd1) ? 2'd1 : 2'd2;
         word = {held0, (gcnt == 2'd2) ? held1 : 8'h00, 8'h00};
      end else begin
         gcnt = 2'd3;
         word = {held0, held1, new_byte};
      end
      grp[0] = '{h2b_pkg::b64_char(word[23:18]), h2b_pkg::STATUS_OK, 1'b0};
      grp[1] = '{h2b_pkg::b64_char(word[17:12]), h2b_pkg::STATUS_OK, 1'b0};
      grp[2] = '{(gcnt > 2'd1) ? h2b_pkg::b64_char(word[11:6]) : h2b_pkg::CHAR_PAD,
                 h2b_pkg::STATUS_OK, 1'b0};
      grp[3] = '{(gcnt > 2'd2) ? h2b_pkg::b64_char(word[5:0]) : h2b_pkg::CHAR_PAD,
                 h2b_pkg::STATUS_OK, 1'b0};
   end

   always_comb begin
      state_nx     = state;
      hold_wr.en   = 1'b0;
      hold_wr.idx  = state.byte_count[0];
      hold_wr.data = new_byte;
      burst        = '0;
      if (end_mark) begin
         state_nx = '0;
         if (state.discarding) begin
            burst.cnt = '0;
         end else if (state.nibble_held) begin
            burst.items[0] = '{8'h00, h2b_pkg::STATUS_ODD, 1'b1};
            burst.cnt      = h2b_pkg::ResCntW'(1);
         end else if (state.byte_count == 2'd0) begin
            burst.items[0] = '{h2b_pkg::CHAR_NEWLINE, h2b_pkg::STATUS_OK, 1'b1};
            burst.cnt      = h2b_pkg::ResCntW'(1);
         end else begin
            burst.items[3:0] = grp;
            burst.items[4]   = '{h2b_pkg::CHAR_NEWLINE, h2b_pkg::STATUS_OK, 1'b1};
            burst.cnt        = h2b_pkg::ResCntW'(5);
         end
      end else if (!state.discarding && !is_space) begin
         if (hv[4]) begin
            state_nx            = '0;
            state_nx.discarding = 1'b1;
            burst.items[0]      = '{8'h00, h2b_pkg::STATUS_BAD_HEX, 1'b1};
            burst.cnt           = h2b_pkg::ResCntW'(1);
         end else if (!state.nibble_held) begin
            state_nx.pending_nibble = hv[3:0];
            state_nx.nibble_held    = 1'b1;
         end else begin
            state_nx.pending_nibble = 4'h0;
            state_nx.nibble_held    = 1'b0;
            if (state.byte_count >= 2'd2) begin
               burst.items[3:0]     = grp;
               burst.cnt            = h2b_pkg::ResCntW'(4);
               state_nx.byte_count  = 2'd0;
            end else begin
               hold_wr.en           = 1'b1;
               state_nx.byte_count  = state.byte_count + 2'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ src/hex_text_to_base64_stream_top.sv @@
// ----------------------------------------------------------------------------
// hex_text_to_base64_stream_top
// Hex text in, one character per item; Base64 characters out.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tlast
// req      in   [7:0] char_in                  end_mark
// rsp      out  [7:0] char_out, [9:8] status   last
//
// One input item enters per cycle unless stalled; it waits in the input register,
// then its results (0 to 5) load a result burst register drained one per cycle
// while rsp_tready is high. An input item with no results loads an empty burst;
// one with n results holds the next item until the last of them is taken.
// Reset is synchronous; stalls on rsp hold the burst and back up into req.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hex_text_to_base64_stream_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] char_out, [9:8] status, [15:10] zero
   output logic             rsp_tlast
);

   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           in_char_ff;
   logic                 in_end_ff;
   h2b_pkg::state_type   state_ff, state_in;
   logic [7:0]           held_ff [2];
   logic [h2b_pkg::ResCntW-1:0]                cnt_ff, cnt_in;
   h2b_pkg::item_type [h2b_pkg::MaxResults-1:0] items_ff, items_in;

   h2b_pkg::hold_wr_type hold_wr;
   h2b_pkg::burst_type   burst;
   logic                 pop, burst_free, in_take, req_take;

   h2b_encode u_encode (
      .state    (state_ff),
      .held0    (held_ff[0]),
      .held1    (held_ff[1]),
      .char_in  (in_char_ff),
      .end_mark (in_end_ff),
      .state_nx (state_in),
      .hold_wr  (hold_wr),
      .burst    (burst)
   );

   always_comb begin
      pop        = rsp_tvalid && rsp_tready;
      burst_free = (cnt_ff == '0) || (cnt_ff == h2b_pkg::ResCntW'(1) && rsp_tready);
      in_take    = in_vld_ff && burst_free;
      req_tready = !in_vld_ff || in_take;
      req_take   = req_tvalid && req_tready;
      in_vld_in  = req_take || (in_vld_ff && !in_take);
   end

   always_comb begin
      cnt_in   = cnt_ff;
      items_in = items_ff;
      if (in_take) begin
         cnt_in   = burst.cnt;
         items_in = burst.items;
      end else if (pop) begin
         cnt_in = cnt_ff - h2b_pkg::ResCntW'(1);
         for (int i = 0; i < h2b_pkg::MaxResults - 1; i++) begin
            items_in[i] = items_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (in_take) begin
            state_ff <= state_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (in_take && hold_wr.en) begin
         held_ff[hold_wr.idx] <= hold_wr.data;
      end
      items_ff <= items_in;
   end

   always_comb begin
      rsp_tvalid = (cnt_ff != '0);
      rsp_tdata  = {6'b000000, items_ff[0].status, items_ff[0].char_out};
      rsp_tlast  = items_ff[0].last;
   end

   `ASSERT_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= h2b_pkg::ResCntW'(h2b_pkg::MaxResults))
   `ASSERT_IMPLIES(a_err_last, clock, reset, rsp_tvalid && rsp_tdata[9:8] != h2b_pkg::STATUS_OK, rsp_tlast)
   `ASSERT_IMPLIES(a_discard_clean, clock, reset, state_ff.discarding, !state_ff.nibble_held && state_ff.byte_count == 2'd0)
   `ASSERT_NEXT(a_in_hold, clock, reset, in_vld_ff && !burst_free, in_vld_ff && $stable(in_char_ff) && $stable(in_end_ff))

endmodule

`default_nettype wire
